// ===== design/ges_pkg.sv =====
package ges_pkg;

	localparam int NumProcs = 32;
	localparam int PidW = 5;
	localparam int PrioW = 8;
	localparam int QuantW = 10;
	localparam int CountW = 16;
	localparam int GoodW = 11;
	localparam logic [QuantW-1:0] QuantMax = '1;
	localparam logic [CountW-1:0] CountMax = '1;

	localparam logic [2:0] OP_ADMIT = 3'd0;
	localparam logic [2:0] OP_RELEASE = 3'd1;
	localparam logic [2:0] OP_READY = 3'd2;
	localparam logic [2:0] OP_RESCHED = 3'd3;
	localparam logic [2:0] OP_PRIO = 3'd4;

	typedef struct packed {
		logic in_use;
		logic ready;
		logic [PrioW-1:0] base;
		logic [PrioW-1:0] eprio;
		logic [QuantW-1:0] quant;
		logic [CountW-1:0] count;
	} slot_t;

	// Candidate passed along the search chain.
	typedef struct packed {
		logic found;
		logic [PidW-1:0] pid;
		logic [GoodW-1:0] good;
		logic [CountW-1:0] count;
	} cand_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic admit;
		logic release_op;
		logic ready;
		logic unready;
		logic prio;
		logic epoch;
		logic charge;
		logic pick;
		logic [PidW-1:0] pid;
		logic [PrioW-1:0] prio_val;
		logic [QuantW-1:0] left;
		logic runnable;
	} cmd_t;

endpackage

// ===== design/goodness_epoch_scheduler.sv =====
// Goodness epoch scheduler over a row of process-slot cells.
// Pulse start with opcode, process_id, priority_req, ticks_left and
// still_runnable while busy is low. Every request yields exactly one result:
// done is high for one cycle with running_pid, granted_quantum,
// ticks_charged, epoch_started and idle_fallback valid in that cycle.
// Admit, release, ready, change priority and unused opcodes pass through the
// apply state to done. A reschedule is stepped by the sequencer through
// charge, search, decide and pick; when a new epoch is computed, an epoch
// update, second search and second decide come before pick. In each search
// the best candidate moves one cell per cycle along the row.
// busy is high from acceptance and is low again in the done cycle; the next request
// can be accepted at the edge that ends the done cycle.
// Reset clears every slot and makes pid 0 current; the block can take a
// request in the first cycle after reset.
// The receiver cannot stall: results are shown once and never held.
module goodness_epoch_scheduler
	import ges_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] opcode,
	input logic [PidW-1:0] process_id,
	input logic [PrioW-1:0] priority_req,
	input logic [QuantW-1:0] ticks_left,
	input logic still_runnable,
	output logic done,
	output logic [PidW-1:0] running_pid,
	output logic [QuantW-1:0] granted_quantum,
	output logic [QuantW-1:0] ticks_charged,
	output logic epoch_started,
	output logic idle_fallback
);

	typedef enum logic [2:0] {
		S_IDLE, S_APPLY, S_CHARGE, S_SEARCH, S_DECIDE, S_EPOCH, S_SEARCH2,
		S_PICK
	} state_t;

	state_t state_q;
	logic [2:0] op_q;
	logic [PidW-1:0] pid_q, cur_q;
	logic [PrioW-1:0] prio_q;
	logic [QuantW-1:0] left_q;
	logic [PidW:0] scnt_q;
	logic run_q, epoch_q;
	cand_t best_q;
	cmd_t cmd;
	cand_t chain [NumProcs+1];
	slot_t slots [NumProcs];
	logic [QuantW-1:0] cur_quant;

	assign chain[0] = '0;

	for (genvar i = 0; i < NumProcs; i++) begin : g_cell
		ges_cell u_cell (
			.clk(clk), .arst_n(arst_n), .my_pid(PidW'(i)), .cmd(cmd),
			.cand_in(chain[i]), .cand_out(chain[i+1]), .slot(slots[i])
		);
	end

	assign cur_quant = slots[cur_q].quant;

	always_comb begin
		cmd = '0;
		cmd.pid = pid_q;
		cmd.prio_val = prio_q;
		cmd.left = left_q;
		cmd.runnable = run_q;
		case (state_q)
			S_APPLY: begin
				cmd.admit = (op_q == OP_ADMIT);
				cmd.release_op = (op_q == OP_RELEASE);
				cmd.ready = (op_q == OP_READY) && (pid_q != cur_q);
				cmd.prio = (op_q == OP_PRIO);
			end
			S_CHARGE: begin
				cmd.pid = cur_q;
				cmd.charge = 1'b1;
			end
			S_EPOCH: begin
				cmd.epoch = 1'b1;
			end
			S_PICK: begin
				cmd.pid = best_q.found ? best_q.pid : '0;
				cmd.pick = best_q.found;
				cmd.unready = !best_q.found;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy <= 1'b0;
			done <= 1'b0;
			cur_q <= '0;
			epoch_q <= 1'b0;
			op_q <= '0;
			pid_q <= '0;
			prio_q <= '0;
			left_q <= '0;
			run_q <= 1'b0;
			scnt_q <= '0;
			best_q <= '0;
			running_pid <= '0;
			granted_quantum <= '0;
			ticks_charged <= '0;
			epoch_started <= 1'b0;
			idle_fallback <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						busy <= 1'b1;
						op_q <= opcode;
						pid_q <= process_id;
						prio_q <= priority_req;
						left_q <= ticks_left;
						run_q <= still_runnable;
						epoch_q <= 1'b0;
						state_q <= (opcode == OP_RESCHED) ? S_CHARGE : S_APPLY;
					end
				end
				S_APPLY: begin
					running_pid <= cur_q;
					granted_quantum <= '0;
					ticks_charged <= '0;
					epoch_started <= 1'b0;
					idle_fallback <= 1'b0;
					done <= 1'b1;
					busy <= 1'b0;
					state_q <= S_IDLE;
				end
				S_CHARGE: begin
					ticks_charged <= (slots[cur_q].in_use && cur_quant > left_q) ?
						cur_quant - left_q : '0;
					scnt_q <= '0;
					state_q <= S_SEARCH;
				end
				S_SEARCH, S_SEARCH2: begin
					if (scnt_q == (PidW+1)'(NumProcs)) begin
						best_q <= chain[NumProcs];
						state_q <= S_DECIDE;
					end else begin
						scnt_q <= scnt_q + 1'b1;
					end
				end
				S_DECIDE: begin
					if (!best_q.found && !epoch_q) begin
						state_q <= S_EPOCH;
					end else begin
						state_q <= S_PICK;
					end
				end
				S_EPOCH: begin
					epoch_q <= 1'b1;
					scnt_q <= '0;
					state_q <= S_SEARCH2;
				end
				S_PICK: begin
					cur_q <= best_q.found ? best_q.pid : '0;
					running_pid <= best_q.found ? best_q.pid : '0;
					granted_quantum <= best_q.found ? slots[best_q.pid].quant :
						slots[0].quant;
					epoch_started <= epoch_q;
					idle_fallback <= !best_q.found;
					done <= 1'b1;
					busy <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");
	a_idle_pid0: assert property (@(posedge clk) disable iff (!arst_n)
		(done && idle_fallback) |-> (running_pid == '0)) else $error("idle pid");

endmodule

// ===== design/ges_cell.sv =====
module ges_cell (
	input logic clk,
	input logic arst_n,
	input logic [ges_pkg::PidW-1:0] my_pid,
	input ges_pkg::cmd_t cmd,
	input ges_pkg::cand_t cand_in,
	output ges_pkg::cand_t cand_out,
	output ges_pkg::slot_t slot
);
	import ges_pkg::*;

	slot_t slot_q;
	cand_t cand_d, cand_q;
	logic hit;
	logic [GoodW-1:0] good;
	logic elig;
	logic [QuantW:0] qsum;

	assign hit = (cmd.pid == my_pid);
	assign slot = slot_q;
	assign cand_out = cand_q;
	assign good = GoodW'(slot_q.eprio) + GoodW'(slot_q.quant);
	assign elig = slot_q.in_use && slot_q.ready && (slot_q.quant != '0);
	assign qsum = (QuantW+1)'(slot_q.quant >> 1) + (QuantW+1)'(slot_q.base);

	always_comb begin
		cand_d = cand_in;
		if (elig && (!cand_in.found || good > cand_in.good ||
			(good == cand_in.good && slot_q.count < cand_in.count))) begin
			cand_d.found = 1'b1;
			cand_d.pid = my_pid;
			cand_d.good = good;
			cand_d.count = slot_q.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			cand_q <= '0;
		end else begin
			cand_q <= cand_d;
			if (cmd.epoch) begin
				if (slot_q.in_use) begin
					slot_q.eprio <= slot_q.base;
					slot_q.quant <= qsum[QuantW] ? QuantMax : qsum[QuantW-1:0];
					slot_q.count <= '0;
				end
			end else if (hit) begin
				if (cmd.admit) begin
					slot_q <= '{in_use: 1'b1, ready: 1'b0, base: cmd.prio_val,
						eprio: '0, quant: '0, count: '0};
				end else if (cmd.release_op) begin
					slot_q.in_use <= 1'b0;
					slot_q.ready <= 1'b0;
				end else if (cmd.ready && slot_q.in_use) begin
					slot_q.ready <= 1'b1;
				end else if (cmd.prio && slot_q.in_use) begin
					slot_q.base <= cmd.prio_val;
				end else if (cmd.charge && slot_q.in_use) begin
					if (slot_q.quant > cmd.left) slot_q.quant <= cmd.left;
					slot_q.ready <= cmd.runnable;
				end else if (cmd.pick) begin
					slot_q.ready <= 1'b0;
					if (slot_q.count != CountMax) slot_q.count <= slot_q.count + 1'b1;
				end else if (cmd.unready) begin
					slot_q.ready <= 1'b0;
				end
			end
		end
	end
endmodule
